>>> design/kmm_pkg.sv
// Shared types and constants for the streaming k-mismatch matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package kmm_pkg;

    localparam int MAX_PATTERN_LEN_DEF = 16;
    localparam int BYTE_W              = 8;
    localparam int PAT_REG_W           = 64;
    localparam int PAT_BYTES_PER_REG   = PAT_REG_W / BYTE_W;
    localparam int LEN_REG_W           = 5;
    localparam int CNT_W               = 5;
    localparam int POS_W               = 32;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 64;
    localparam int S_TDATA_W           = 8;
    localparam int M_TDATA_W           = 40;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd4;

    localparam logic [LEN_REG_W-1:0] PATTERN_LENGTH_RST = 5'd1;

    typedef struct packed {
        logic [PAT_REG_W-1:0] pattern_low;
        logic [PAT_REG_W-1:0] pattern_high;
        logic [LEN_REG_W-1:0] pattern_length;
        logic [CNT_W-1:0]     mismatch_limit;
        logic                 restart;
        logic [POS_W-1:0]     start_position;
    } kmm_cfg_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] match_start;
        logic [CNT_W-1:0] mismatch_count;
    } kmm_result_t;

endpackage
`default_nettype wire

>>> design/streaming_k_mismatch_matcher_top.sv
// Streaming k-mismatch matcher: one byte per word in, one match per word out.
// A match is registered and shows on m_tvalid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the window cells and the output register set it.
// s_tready drops only while a finished match waits in the output register.
// Reset: synchronous active-low; closes all windows, position 0, registers to defaults.
// Depends on kmm_pkg, kmm_cfg_regs and kmm_window_array.
`timescale 1ns / 1ps
`default_nettype none
module streaming_k_mismatch_matcher_top
    import kmm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] match_start, [36:32] mismatch_count
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    kmm_cfg_t         cfg;
    kmm_result_t      result;
    logic             accept;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [POS_W-1:0] match_start_reg;
    logic [CNT_W-1:0] mismatch_count_reg;

    assign cfg_ready = 1'b1;

    kmm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kmm_window_array #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_window_array (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .advance   (accept),
        .data_byte (s_tdata[BYTE_W-1:0]),
        .result    (result)
    );

    // Take a new word whenever the output slot is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = result.hit;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && result.hit) begin
            match_start_reg    <= result.match_start;
            mismatch_count_reg <= result.mismatch_count;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - POS_W - CNT_W)'(0), mismatch_count_reg, match_start_reg};

endmodule
`default_nettype wire

>>> design/kmm_cfg_regs.sv
// Configuration register file of the k-mismatch matcher.
// Depends on kmm_pkg; a start_position write also raises a one-cycle restart.
`timescale 1ns / 1ps
`default_nettype none
module kmm_cfg_regs
    import kmm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output kmm_cfg_t                   cfg
);

    logic [PAT_REG_W-1:0] pattern_low_reg;
    logic [PAT_REG_W-1:0] pattern_high_reg;
    logic [LEN_REG_W-1:0] pattern_length_reg;
    logic [CNT_W-1:0]     mismatch_limit_reg;
    logic [POS_W-1:0]     start_position_reg;
    logic                 restart;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= PATTERN_LENGTH_RST;
            mismatch_limit_reg <= '0;
            start_position_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_REG_W-1:0];
                REG_MISMATCH_LIMIT: mismatch_limit_reg <= cfg_data[CNT_W-1:0];
                REG_START_POSITION: start_position_reg <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Restart acts in the write cycle itself, with the written value
    assign restart = cfg_valid && (cfg_index == REG_START_POSITION);

    always_comb begin
        cfg.pattern_low    = pattern_low_reg;
        cfg.pattern_high   = pattern_high_reg;
        cfg.pattern_length = pattern_length_reg;
        cfg.mismatch_limit = mismatch_limit_reg;
        cfg.restart        = restart;
        cfg.start_position = restart ? cfg_data[POS_W-1:0] : start_position_reg;
    end

endmodule
`default_nettype wire

>>> design/kmm_window_array.sv
// Row of window cells: one mismatch counter per open alignment window.
// Depends on kmm_pkg; all cells update in parallel on each accepted byte.
`timescale 1ns / 1ps
`default_nettype none
module kmm_window_array
    import kmm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kmm_cfg_t          cfg,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] data_byte,
    output kmm_result_t            result
);

    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CMP_W = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;

    logic [CNT_W-1:0]           mm_reg    [MAX_PATTERN_LEN];
    logic [CNT_W-1:0]           mm_next   [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] valid_reg;
    logic [MAX_PATTERN_LEN-1:0] valid_next;
    logic [POS_W-1:0]           pos_reg;
    logic [CNT_W:0]             cell_m    [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] keep;
    logic [MAX_PATTERN_LEN-1:0] last_cell;
    logic [CMP_W-1:0]           len_raw;
    logic [LEN_W-1:0]           len_eff;

    // Clamp the configured length into 1..MAX_PATTERN_LEN
    always_comb begin
        len_raw = CMP_W'(cfg.pattern_length);
        if (len_raw == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_raw > CMP_W'(MAX_PATTERN_LEN)) begin
            len_eff = LEN_W'(MAX_PATTERN_LEN);
        end else begin
            len_eff = len_raw[LEN_W-1:0];
        end
    end

    assign valid_next[0] = 1'b0;
    assign mm_next[0]    = '0;

    for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_cell
        logic [BYTE_W-1:0] pat_byte;
        logic [CNT_W-1:0]  base;
        logic              open;

        if (i < PAT_BYTES_PER_REG) begin : g_lo
            assign pat_byte = cfg.pattern_low[BYTE_W*i +: BYTE_W];
        end else if (i < 2 * PAT_BYTES_PER_REG) begin : g_hi
            assign pat_byte = cfg.pattern_high[BYTE_W*(i-PAT_BYTES_PER_REG) +: BYTE_W];
        end else begin : g_zero
            assign pat_byte = '0;
        end

        // Cell 0 is the window opened by the current byte
        if (i == 0) begin : g_first
            assign base = '0;
            assign open = 1'b1;
        end else begin : g_rest
            assign base = mm_reg[i];
            assign open = valid_reg[i];
        end

        assign cell_m[i]    = {1'b0, base} + {{CNT_W{1'b0}}, (data_byte != pat_byte)};
        assign keep[i]      = open && (LEN_W'(i) < len_eff)
                              && (cell_m[i] <= {1'b0, cfg.mismatch_limit});
        assign last_cell[i] = (LEN_W'(i + 1) == len_eff);

        if (i + 1 < MAX_PATTERN_LEN) begin : g_shift
            assign valid_next[i+1] = keep[i] && !last_cell[i];
            assign mm_next[i+1]    = cell_m[i][CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            pos_reg   <= '0;
        end else if (cfg.restart) begin
            valid_reg <= '0;
            pos_reg   <= cfg.start_position;
        end else if (advance) begin
            valid_reg <= valid_next;
            pos_reg   <= pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mm_reg <= mm_next;
        end
    end

    // Only the cell at offset length-1 can finish a window
    always_comb begin
        result.hit            = 1'b0;
        result.mismatch_count = '0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (keep[i] && last_cell[i]) begin
                result.hit            = 1'b1;
                result.mismatch_count = cell_m[i][CNT_W-1:0];
            end
        end
        result.match_start = pos_reg - POS_W'(len_eff - LEN_W'(1));
    end

endmodule
`default_nettype wire

>>> tb/streaming_k_mismatch_matcher_top_tb.sv
// Self-checking testbench for streaming_k_mismatch_matcher_top: random byte streams
// with planted pattern copies, random register settings, and a cycle-free match predictor.
// Depends on kmm_pkg and the matcher RTL only.
`timescale 1ns / 1ps
module streaming_k_mismatch_matcher_top_tb;
    import kmm_pkg::*;

    localparam int PAT_MAX       = MAX_PATTERN_LEN_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int STREAM_BYTES  = 950;
    localparam int QUIET_TAIL    = 150;

    typedef struct {
        logic [POS_W-1:0] start;
        logic [CNT_W-1:0] count;
    } match_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] data_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [31:0] match_start, [36:32] mismatch_count
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the matcher's registers and window cells
    logic [PAT_REG_W-1:0] pat_lo     = '0;
    logic [PAT_REG_W-1:0] pat_hi     = '0;
    logic [LEN_REG_W-1:0] pat_len    = PATTERN_LENGTH_RST;
    logic [CNT_W-1:0]     mm_limit   = '0;
    logic [POS_W-1:0]     stream_pos = '0;
    int unsigned          win_count [PAT_MAX];
    bit                   win_open  [PAT_MAX];

    logic [BYTE_W-1:0] byte_queue[$];
    match_t            pending_matches[$];

    bit s_took;
    bit idle_on = 1'b1;
    int src_gap;
    int sink_hold;
    int errors;
    int bytes_sent;
    int matches_seen;
    int reg_writes;
    int phases;

    streaming_k_mismatch_matcher_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned active_length();
        if (pat_len == 0) return 1;
        if (pat_len > PAT_MAX) return PAT_MAX;
        return pat_len;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(int unsigned k);
        if (k < PAT_BYTES_PER_REG) return pat_lo[BYTE_W*k +: BYTE_W];
        return pat_hi[BYTE_W*(k-PAT_BYTES_PER_REG) +: BYTE_W];
    endfunction

    // Advance every open window by one byte and queue the match it completes, if any.
    function automatic void scan_byte(logic [BYTE_W-1:0] b);
        int unsigned len;
        int unsigned cnt;
        int unsigned nxt_count [PAT_MAX];
        bit          nxt_open  [PAT_MAX];
        match_t      hit;
        for (int i = 0; i < PAT_MAX; i++) begin
            nxt_count[i] = 0;
            nxt_open[i]  = 1'b0;
        end
        len = active_length();
        for (int unsigned i = 0; i < len; i++) begin
            if (i != 0 && !win_open[i]) continue;
            cnt = ((i == 0) ? 0 : win_count[i]) + ((b != pattern_byte(i)) ? 1 : 0);
            if (cnt > mm_limit) continue;
            if (i + 1 == len) begin
                hit.start = stream_pos - POS_W'(i);
                hit.count = CNT_W'(cnt);
                pending_matches = {pending_matches, hit};
            end else begin
                nxt_count[i+1] = cnt;
                nxt_open[i+1]  = 1'b1;
            end
        end
        win_count = nxt_count;
        win_open  = nxt_open;
        stream_pos++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PATTERN_LOW:    pat_lo   = value;
            REG_PATTERN_HIGH:   pat_hi   = value;
            REG_PATTERN_LENGTH: pat_len  = value[LEN_REG_W-1:0];
            REG_MISMATCH_LIMIT: mm_limit = value[CNT_W-1:0];
            REG_START_POSITION: begin
                stream_pos = value[POS_W-1:0];
                for (int i = 0; i < PAT_MAX; i++) begin
                    win_count[i] = 0;
                    win_open[i]  = 1'b0;
                end
            end
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every byte is taken and every match has come back, then let the pipe settle.
    task automatic drain();
        while (byte_queue.size() != 0 || s_tvalid || pending_matches.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_settings();
        logic [2*PAT_REG_W-1:0] pat;
        logic [BYTE_W-1:0]      letters [3];
        logic [CFG_DATA_W-1:0]  junk;
        int                     kind;
        int                     r;
        if ($urandom_range(0, 2) != 0) begin
            kind = $urandom_range(0, 5);
            for (int i = 0; i < 3; i++) letters[i] = BYTE_W'($urandom);
            for (int i = 0; i < 2*PAT_BYTES_PER_REG; i++) begin
                case (kind)
                    0:       pat[BYTE_W*i +: BYTE_W] = BYTE_W'($urandom);
                    1:       pat[BYTE_W*i +: BYTE_W] = '0;
                    2:       pat[BYTE_W*i +: BYTE_W] = '1;
                    default: pat[BYTE_W*i +: BYTE_W] = letters[$urandom_range(0, 2)];
                endcase
            end
            write_reg(REG_PATTERN_LOW, pat[PAT_REG_W-1:0]);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_PATTERN_HIGH, pat[2*PAT_REG_W-1:PAT_REG_W]);
        end
        if ($urandom_range(0, 1) != 0) begin
            r = $urandom_range(0, 19);
            junk = {$urandom, $urandom};
            if (r == 0)      junk[LEN_REG_W-1:0] = '0;
            else if (r == 1) junk[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(PAT_MAX + 1, 31));
            else if (r < 5)  junk[LEN_REG_W-1:0] = LEN_REG_W'(PAT_MAX);
            else             junk[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(1, 8));
            write_reg(REG_PATTERN_LENGTH, junk);
        end
        if ($urandom_range(0, 1) != 0) begin
            junk = {$urandom, $urandom};
            if ($urandom_range(0, 4) == 0) junk[CNT_W-1:0] = CNT_W'($urandom_range(PAT_MAX, 31));
            else                           junk[CNT_W-1:0] = CNT_W'($urandom_range(0, 3));
            write_reg(REG_MISMATCH_LIMIT, junk);
        end
        // Leave the start alone about half the time so open windows see the new settings
        if ($urandom_range(0, 1) != 0) begin
            junk = {$urandom, $urandom};
            r = $urandom_range(0, 3);
            if (r == 0)      junk[POS_W-1:0] = '0;
            else if (r == 1) junk[POS_W-1:0] = '1 - POS_W'($urandom_range(0, 40));
            write_reg(REG_START_POSITION, junk);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_IDX_W'($urandom_range(int'(REG_START_POSITION) + 1,
                                                (1 << CFG_IDX_W) - 1)),
                      {$urandom, $urandom});
    endtask

    // Mostly pattern copies with a few corrupted bytes, the rest noise.
    task automatic plan_bytes(int n);
        int                len;
        int                left;
        int                cuts;
        logic [BYTE_W-1:0] chunk [PAT_MAX];
        len  = active_length();
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 9) < 6) begin
                for (int i = 0; i < len; i++) chunk[i] = pattern_byte(i);
                cuts = $urandom_range(0, 3);
                for (int i = 0; i < cuts; i++) chunk[$urandom_range(0, len - 1)] = BYTE_W'($urandom);
                for (int i = 0; i < len; i++) byte_queue = {byte_queue, chunk[i]};
                left -= len;
            end else begin
                cuts = $urandom_range(1, 6);
                for (int i = 0; i < cuts; i++)
                    byte_queue = {byte_queue,
                                  (($urandom_range(0, 1) != 0) ? BYTE_W'($urandom)
                                   : pattern_byte($urandom_range(0, len - 1)))};
                left -= cuts;
            end
        end
    endtask

    // Source side: hold a word until taken, otherwise idle or advance.
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_took)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                src_gap = $urandom_range(0, 16);
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                s_tdata  <= byte_queue.pop_front();
                s_tvalid <= 1'b1;
                bytes_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random stall bursts.
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_hold = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        match_t want;
        s_took = s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_matches.size() == 0) begin
                    errors++;
                    $display("%0t: match word %h with none expected", $time, m_tdata);
                end else begin
                    want = pending_matches.pop_front();
                    matches_seen++;
                    if (m_tdata[POS_W-1:0] !== want.start) begin
                        errors++;
                        $display("%0t: match_start expected %h, got %h",
                                 $time, want.start, m_tdata[POS_W-1:0]);
                    end
                    if (m_tdata[POS_W +: CNT_W] !== want.count) begin
                        errors++;
                        $display("%0t: mismatch_count expected %0d, got %0d",
                                 $time, want.count, m_tdata[POS_W +: CNT_W]);
                    end
                    if (m_tdata[M_TDATA_W-1:POS_W+CNT_W] !== '0) begin
                        errors++;
                        $display("%0t: pad bits expected 0, got %b",
                                 $time, m_tdata[M_TDATA_W-1:POS_W+CNT_W]);
                    end
                end
            end
            if (s_took) scan_byte(s_tdata);
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] junk;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset defaults: one-byte pattern of zero, no mismatches allowed
        byte_queue = {byte_queue, 8'h00};
        byte_queue = {byte_queue, 8'hFF};
        byte_queue = {byte_queue, 8'h00};
        drain();

        // Full-length exact match straddling the position wrap
        write_reg(REG_PATTERN_LOW,    64'h7E81_F00F_5AA5_00FF);
        write_reg(REG_PATTERN_HIGH,   64'h0123_4567_89AB_CDEF);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(PAT_MAX));
        write_reg(REG_MISMATCH_LIMIT, '0);
        write_reg(REG_START_POSITION, 64'h0000_0000_FFFF_FFF8);
        for (int i = 0; i < PAT_MAX; i++) byte_queue = {byte_queue, pattern_byte(i)};
        drain();

        // Zero length, oversized limit with junk upper bits, writes to unused indexes
        junk = {$urandom, $urandom};
        junk[LEN_REG_W-1:0] = '0;
        write_reg(REG_PATTERN_LENGTH, junk);
        junk = {$urandom, $urandom};
        junk[CNT_W-1:0] = '1;
        write_reg(REG_MISMATCH_LIMIT, junk);
        for (int k = int'(REG_START_POSITION) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        for (int i = 0; i < 5; i++) byte_queue = {byte_queue, BYTE_W'($urandom)};
        drain();
        phases = 3;

        while (bytes_sent < STREAM_BYTES) begin
            idle_on = (bytes_sent < STREAM_BYTES - QUIET_TAIL);
            random_settings();
            plan_bytes($urandom_range(10, 60));
            drain();
            phases++;
        end

        $display("Checked %0d matches from %0d stream bytes across %0d setting phases",
                 matches_seen, bytes_sent, phases);
        $display("with %0d register writes.", reg_writes);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out waiting for the matcher.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
design/kmm_pkg.sv
design/kmm_cfg_regs.sv
design/kmm_window_array.sv
design/streaming_k_mismatch_matcher_top.sv
tb/streaming_k_mismatch_matcher_top_tb.sv
